[rtl/yuyv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package yuyv_pkg;

  localparam int MAX_ROW_MACROPIXELS = 1024;
  localparam int COL_W = $clog2(MAX_ROW_MACROPIXELS);
  localparam int ROW_LEN_W = 11;
  localparam int CFG_DATA_W = 11;
  localparam int SAMPLE_W = 8;
  localparam int WORD_W = 4 * SAMPLE_W;

  typedef enum logic {
    REG_HALF_MODE       = 1'b0,
    REG_ROW_MACROPIXELS = 1'b1
  } reg_index_t;

endpackage

`default_nettype wire

[rtl/yuyv_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface yuyv_macropixel_if;
  import yuyv_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] luma_first;
  logic [SAMPLE_W-1:0] chroma_blue;
  logic [SAMPLE_W-1:0] luma_second;
  logic [SAMPLE_W-1:0] chroma_red;
  logic                frame_start;

  modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                  frame_start, input ready);
  modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                frame_start, output ready);
endinterface

interface yuyv_pixel_if;
  import yuyv_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] pix_y;
  logic [SAMPLE_W-1:0] pix_u;
  logic [SAMPLE_W-1:0] pix_v;
  logic                row_end;
  logic                run_last;

  modport source (output valid, pix_y, pix_u, pix_v, row_end, run_last, input ready);
  modport sink (input valid, pix_y, pix_u, pix_v, row_end, run_last, output ready);
endinterface

`default_nettype wire

[rtl/yuyv_to_yuv444_converter_unit.sv]
// Channel     | Dir | Handshake    | Payload
// macropixel  | in  | valid/ready  | luma_first, chroma_blue, luma_second, chroma_red,
//             |     |              | frame_start
// pixel       | out | valid/ready  | pix_y, pix_u, pix_v, row_end, run_last
// config      | in  | write_enable | reg_index, write_data
//
// Full mode: one pixel per cycle through the single output register unless stalled; a
// new macropixel enters as the last one's second pixel goes out. Half mode: one macropixel
// per cycle unless stalled. A macropixel and its line store read register in the work
// stage, then output. Synchronous reset clears counters, row parity, configuration
// registers and valids; the line store is not cleared and needs no clearing pass.
// Output stalls back up through the work stage into macropixel.ready.
`timescale 1ns / 1ps
`default_nettype none

module yuyv_to_yuv444_converter_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  yuyv_macropixel_if.sink                    macropixel,
  yuyv_pixel_if.source                       pixel,
  input  wire logic                          write_enable,
  input  wire logic                          reg_index,
  input  wire logic [yuyv_pkg::CFG_DATA_W-1:0] write_data
);
  import yuyv_pkg::*;

  // configuration
  logic                 half_mode;
  logic [ROW_LEN_W-1:0] row_macropixels;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_mode       <= 1'b0;
      row_macropixels <= ROW_LEN_W'(320);
    end else if (write_enable) begin
      case (reg_index_t'(reg_index))
        REG_HALF_MODE:       half_mode       <= write_data[0];
        REG_ROW_MACROPIXELS: row_macropixels <= write_data[ROW_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // position tracking
  logic [COL_W-1:0]     column_count;
  logic                 odd_row;
  logic [COL_W-1:0]     col;
  logic                 odd_cur;
  logic [ROW_LEN_W-1:0] row_len;
  logic                 last_col;
  logic                 accept;
  logic                 store_row;

  always_comb begin
    col     = macropixel.frame_start ? '0 : column_count;
    odd_cur = macropixel.frame_start ? 1'b0 : odd_row;
    if (row_macropixels == '0) begin
      row_len = ROW_LEN_W'(1);
    end else if (row_macropixels > ROW_LEN_W'(MAX_ROW_MACROPIXELS)) begin
      row_len = ROW_LEN_W'(MAX_ROW_MACROPIXELS);
    end else begin
      row_len = row_macropixels;
    end
    last_col  = (ROW_LEN_W'(col) + ROW_LEN_W'(1)) >= row_len;
    store_row = half_mode && !odd_cur;
  end

  assign accept = macropixel.valid && macropixel.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      odd_row      <= 1'b0;
    end else if (accept) begin
      column_count <= last_col ? '0 : col + COL_W'(1);
      odd_row      <= last_col ? !odd_cur : odd_cur;
    end
  end

  // line store: even half-mode rows write, the odd row one row later reads; every accept
  // reads, so an even-row write and its read touch the same entry in the same cycle
  logic [WORD_W-1:0] line_store [MAX_ROW_MACROPIXELS];
  logic [WORD_W-1:0] above;

  always_ff @(posedge clk) begin
    if (accept && store_row) begin
      line_store[col] <= {macropixel.chroma_red, macropixel.luma_second,
                          macropixel.chroma_blue, macropixel.luma_first};
    end
    if (accept) begin
      above <= line_store[col];
    end
  end

  // work stage
  logic                s2_valid;
  logic                s2_half;
  logic                s2_phase;
  logic                s2_last_col;
  logic [SAMPLE_W-1:0] s2_y0;
  logic [SAMPLE_W-1:0] s2_u;
  logic [SAMPLE_W-1:0] s2_y1;
  logic [SAMPLE_W-1:0] s2_v;
  logic                out_free;
  logic                s2_fire;
  logic                s2_done;

  assign out_free         = !pixel.valid || pixel.ready;
  assign s2_fire          = s2_valid && out_free;
  assign s2_done          = s2_fire && (s2_half || s2_phase);
  assign macropixel.ready = !s2_valid || s2_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_phase <= 1'b0;
    end else if (accept) begin
      s2_valid <= !store_row;
      s2_phase <= 1'b0;
    end else if (s2_done) begin
      s2_valid <= 1'b0;
    end else if (s2_fire) begin
      s2_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_half     <= half_mode;
      s2_last_col <= last_col;
      s2_y0       <= macropixel.luma_first;
      s2_u        <= macropixel.chroma_blue;
      s2_y1       <= macropixel.luma_second;
      s2_v        <= macropixel.chroma_red;
    end
  end

  logic [SAMPLE_W+1:0] y_sum;
  logic [SAMPLE_W:0]   u_sum;
  logic [SAMPLE_W:0]   v_sum;
  logic [SAMPLE_W-1:0] y_next;
  logic [SAMPLE_W-1:0] u_next;
  logic [SAMPLE_W-1:0] v_next;
  logic                row_end_next;
  logic                run_last_next;

  always_comb begin
    y_sum = (SAMPLE_W+2)'(s2_y0) + (SAMPLE_W+2)'(s2_y1)
          + (SAMPLE_W+2)'(above[SAMPLE_W-1:0])
          + (SAMPLE_W+2)'(above[3*SAMPLE_W-1:2*SAMPLE_W]);
    u_sum = (SAMPLE_W+1)'(s2_u) + (SAMPLE_W+1)'(above[2*SAMPLE_W-1:SAMPLE_W]);
    v_sum = (SAMPLE_W+1)'(s2_v) + (SAMPLE_W+1)'(above[4*SAMPLE_W-1:3*SAMPLE_W]);
    if (s2_half) begin
      y_next        = y_sum[SAMPLE_W+1:2];
      u_next        = u_sum[SAMPLE_W:1];
      v_next        = v_sum[SAMPLE_W:1];
      row_end_next  = s2_last_col;
      run_last_next = 1'b1;
    end else begin
      y_next        = s2_phase ? s2_y1 : s2_y0;
      u_next        = s2_u;
      v_next        = s2_v;
      row_end_next  = s2_phase && s2_last_col;
      run_last_next = s2_phase;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (s2_fire) begin
      pixel.valid <= 1'b1;
    end else if (pixel.ready) begin
      pixel.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      pixel.pix_y    <= y_next;
      pixel.pix_u    <= u_next;
      pixel.pix_v    <= v_next;
      pixel.row_end  <= row_end_next;
      pixel.run_last <= run_last_next;
    end
  end

  // checks
  a_half_single: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_phase) |-> !s2_half)
    else $error("second pixel pending for a half-mode transaction");

  a_even_row_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && store_row) |=> !s2_valid)
    else $error("even row in half mode produced work");

  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && last_col) |=> (column_count == '0))
    else $error("column count did not wrap at row end");

  a_row_end_last: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.row_end) |-> pixel.run_last)
    else $error("row end flagged on a non-final pixel");

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import yuyv_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_ITEMS = 1150;

  typedef struct packed {
    logic [SAMPLE_W-1:0] y0;
    logic [SAMPLE_W-1:0] u;
    logic [SAMPLE_W-1:0] y1;
    logic [SAMPLE_W-1:0] v;
    logic                fs;
  } macropixel_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] u;
    logic [SAMPLE_W-1:0] v;
    logic                row_end;
    logic                run_last;
  } pixel_t;

  logic                  clk;
  logic                  rst;
  logic                  write_enable;
  reg_index_t            reg_index;
  logic [CFG_DATA_W-1:0] write_data;

  yuyv_macropixel_if mp_bus();
  yuyv_pixel_if      px_bus();

  yuyv_to_yuv444_converter_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .macropixel   (mp_bus),
    .pixel        (px_bus),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  // Mirror of the converter state
  bit                   half_cfg;
  logic [ROW_LEN_W-1:0] row_len_cfg;
  int unsigned          col_pos;
  bit                   odd_row;
  logic [WORD_W-1:0]    line_mirror [MAX_ROW_MACROPIXELS];
  bit                   written [MAX_ROW_MACROPIXELS];
  pixel_t               pixel_fifo [$];

  int  error_count;
  int  items_sent;
  int  cycles;
  int  hold_request;
  bit  src_idling;
  bit  sink_idling;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic macropixel_t make_mp(input bit fs, input logic [7:0] y0, input logic [7:0] u,
                                          input logic [7:0] y1, input logic [7:0] v);
    macropixel_t m;
    m.y0 = y0;
    m.u  = u;
    m.y1 = y1;
    m.v  = v;
    m.fs = fs;
    return m;
  endfunction

  function automatic macropixel_t random_mp(input bit fs);
    return make_mp(fs, SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                   SAMPLE_W'($urandom));
  endfunction

  function automatic int unsigned effective_row_len();
    if (row_len_cfg == 0) return 1;
    if (row_len_cfg > MAX_ROW_MACROPIXELS) return MAX_ROW_MACROPIXELS;
    return 32'(row_len_cfg);
  endfunction

  // Expected pixels for one accepted macropixel
  function automatic void predict_pixels(input macropixel_t m);
    int unsigned       col;
    int unsigned       ysum;
    int unsigned       usum;
    int unsigned       vsum;
    bit                row_done;
    logic [WORD_W-1:0] w;
    pixel_t            p;
    if (m.fs) begin
      col_pos = 0;
      odd_row = 1'b0;
    end
    col = (col_pos >= MAX_ROW_MACROPIXELS) ? MAX_ROW_MACROPIXELS - 1 : col_pos;
    row_done = (col + 1 >= effective_row_len());
    if (half_cfg) begin
      if (!odd_row) begin
        line_mirror[col] = {m.v, m.y1, m.u, m.y0};
        written[col] = 1'b1;
      end else begin
        w = line_mirror[col];
        ysum = int'(m.y0) + int'(m.y1) + int'(w[7:0]) + int'(w[23:16]);
        usum = int'(m.u) + int'(w[15:8]);
        vsum = int'(m.v) + int'(w[31:24]);
        p.y = SAMPLE_W'(ysum >> 2);
        p.u = SAMPLE_W'(usum >> 1);
        p.v = SAMPLE_W'(vsum >> 1);
        p.row_end = row_done;
        p.run_last = 1'b1;
        pixel_fifo.push_back(p);
      end
    end else begin
      p = '{y: m.y0, u: m.u, v: m.v, row_end: 1'b0, run_last: 1'b0};
      pixel_fifo.push_back(p);
      p = '{y: m.y1, u: m.u, v: m.v, row_end: row_done, run_last: 1'b1};
      pixel_fifo.push_back(p);
    end
    if (row_done) begin
      col_pos = 0;
      odd_row = ~odd_row;
    end else begin
      col_pos = col + 1;
    end
  endfunction

  function automatic void log_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  // Pixel checker
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (!rst && px_bus.valid && px_bus.ready) begin
      got = '{y: px_bus.pix_y, u: px_bus.pix_u, v: px_bus.pix_v,
              row_end: px_bus.row_end, run_last: px_bus.run_last};
      if (pixel_fifo.size() == 0) begin
        log_error($sformatf("unexpected pixel y=%0d u=%0d v=%0d row_end=%0b run_last=%0b",
                            got.y, got.u, got.v, got.row_end, got.run_last));
      end else begin
        want = pixel_fifo.pop_front();
        if (got.y !== want.y || got.u !== want.u || got.v !== want.v ||
            got.row_end !== want.row_end || got.run_last !== want.run_last)
          log_error($sformatf({"pixel mismatch: exp y=%0d u=%0d v=%0d row_end=%0b run_last=%0b",
                               " got y=%0d u=%0d v=%0d row_end=%0b run_last=%0b"},
                              want.y, want.u, want.v, want.row_end, want.run_last,
                              got.y, got.u, got.v, got.row_end, got.run_last));
      end
    end
  end

  // Pixel sink: random or no stalls, plus long hold-offs on request
  initial begin : pixel_sink
    int stall;
    stall = 0;
    px_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else if (stall == 0 && sink_idling) begin
        stall = idle_gap();
      end
      if (stall > 0) begin
        px_bus.ready = 1'b0;
        stall--;
      end else begin
        px_bus.ready = 1'b1;
      end
    end
  end

  // Entered and left at a falling edge
  task automatic send_macropixel(input macropixel_t m);
    int          gap;
    int unsigned col;
    col = (col_pos >= MAX_ROW_MACROPIXELS) ? MAX_ROW_MACROPIXELS - 1 : col_pos;
    // never let an odd half-mode row read a line store entry no even row wrote
    if (!m.fs && half_cfg && odd_row && !written[col]) m.fs = 1'b1;
    gap = src_idling ? idle_gap() : 0;
    if (gap > 0) begin
      mp_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mp_bus.valid       = 1'b1;
    mp_bus.luma_first  = m.y0;
    mp_bus.chroma_blue = m.u;
    mp_bus.luma_second = m.y1;
    mp_bus.chroma_red  = m.v;
    mp_bus.frame_start = m.fs;
    @(posedge clk);
    while (!mp_bus.ready) @(posedge clk);
    predict_pixels(m);
    items_sent++;
    @(negedge clk);
  endtask

  // Drain all pending pixels; extra cycles cover even rows that emit nothing
  task automatic settle_pipeline();
    mp_bus.valid = 1'b0;
    while (pixel_fifo.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    write_enable = 1'b1;
    reg_index    = idx;
    write_data   = data;
    @(negedge clk);
    write_enable = 1'b0;
    if (idx == REG_HALF_MODE) half_cfg = data[0];
    else row_len_cfg = data[ROW_LEN_W-1:0];
  endtask

  task automatic test_reset_defaults();
    send_macropixel(make_mp(1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
    send_macropixel(make_mp(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_macropixel(make_mp(1'b0, 8'hAA, 8'h55, 8'h55, 8'hAA));
  endtask

  task automatic test_full_mode_extremes();
    settle_pipeline();
    sink_idling = 1'b1;
    write_reg(REG_ROW_MACROPIXELS, 11'd3);
    write_reg(REG_HALF_MODE, 11'd0);
    send_macropixel(make_mp(1'b1, 8'h55, 8'hAA, 8'hAA, 8'h55));
    send_macropixel(make_mp(1'b0, 8'hFF, 8'h00, 8'hFF, 8'h00));
    send_macropixel(make_mp(1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF));
    send_macropixel(make_mp(1'b0, 8'h01, 8'h80, 8'h7F, 8'hFE));
    // frame start in the middle of a row restarts the column count
    send_macropixel(make_mp(1'b1, 8'h80, 8'h01, 8'hFE, 8'h7F));
  endtask

  task automatic test_half_mode_average();
    settle_pipeline();
    write_reg(REG_HALF_MODE, 11'd1);
    write_reg(REG_ROW_MACROPIXELS, 11'd2);
    send_macropixel(make_mp(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_macropixel(make_mp(1'b0, 8'h01, 8'h00, 8'h02, 8'h01));
    send_macropixel(make_mp(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_macropixel(make_mp(1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
    settle_pipeline();
    write_reg(REG_ROW_MACROPIXELS, 11'd1);
    // truncation of the sums
    send_macropixel(make_mp(1'b0, 8'h03, 8'h01, 8'h00, 8'hFE));
    send_macropixel(make_mp(1'b0, 8'h00, 8'h00, 8'h00, 8'hFF));
  endtask

  task automatic test_row_length_limits();
    settle_pipeline();
    write_reg(REG_HALF_MODE, 11'd0);
    // zero counts as one: every macropixel ends a row
    write_reg(REG_ROW_MACROPIXELS, 11'd0);
    send_macropixel(random_mp(1'b1));
    send_macropixel(random_mp(1'b0));
    send_macropixel(random_mp(1'b0));
    settle_pipeline();
    write_reg(REG_ROW_MACROPIXELS, 11'd2047);
    send_macropixel(random_mp(1'b1));
    send_macropixel(random_mp(1'b0));
    settle_pipeline();
    write_reg(REG_ROW_MACROPIXELS, 11'd1024);
    send_macropixel(random_mp(1'b0));
    // row length lowered below the current column ends the row at once
    settle_pipeline();
    write_reg(REG_ROW_MACROPIXELS, 11'd4);
    send_macropixel(random_mp(1'b1));
    send_macropixel(random_mp(1'b0));
    send_macropixel(random_mp(1'b0));
    settle_pipeline();
    write_reg(REG_ROW_MACROPIXELS, 11'd2);
    send_macropixel(random_mp(1'b0));
    send_macropixel(random_mp(1'b0));
  endtask

  task automatic test_output_backpressure();
    settle_pipeline();
    write_reg(REG_HALF_MODE, 11'd0);
    write_reg(REG_ROW_MACROPIXELS, 11'd6);
    src_idling = 1'b0;
    @(posedge clk);
    hold_request = 300;
    @(negedge clk);
    for (int i = 0; i < 40; i++) send_macropixel(random_mp(i == 0));
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_row_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 13) return CFG_DATA_W'(MAX_ROW_MACROPIXELS);
    if (r < 16) return 11'd2047;
    if (r < 20) return CFG_DATA_W'($urandom_range(MAX_ROW_MACROPIXELS + 1, 2046));
    if (r < 28) return CFG_DATA_W'($urandom_range(9, 200));
    return CFG_DATA_W'($urandom_range(1, 8));
  endfunction

  task automatic test_random_traffic();
    int                    first_sent;
    int unsigned           n_items;
    logic [CFG_DATA_W-1:0] data;
    bit                    fs;
    first_sent = items_sent;
    while (items_sent - first_sent < RANDOM_ITEMS) begin
      settle_pipeline();
      src_idling  = ($urandom_range(0, 2) != 0);
      sink_idling = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 3) != 0) begin
        // upper bits of the mode write are don't-care
        data = CFG_DATA_W'($urandom);
        data[0] = 1'($urandom_range(0, 1));
        write_reg(REG_HALF_MODE, data);
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_ROW_MACROPIXELS, pick_row_len());
      n_items = effective_row_len() * $urandom_range(2, 6);
      if (n_items > 80) n_items = 80;
      for (int i = 0; i < n_items; i++) begin
        fs = (i == 0 && $urandom_range(0, 4) != 0) || ($urandom_range(0, 24) == 0);
        send_macropixel(random_mp(fs));
      end
    end
  endtask

  initial begin
    rst                = 1'b1;
    write_enable       = 1'b0;
    reg_index          = REG_HALF_MODE;
    write_data         = '0;
    mp_bus.valid       = 1'b0;
    mp_bus.luma_first  = '0;
    mp_bus.chroma_blue = '0;
    mp_bus.luma_second = '0;
    mp_bus.chroma_red  = '0;
    mp_bus.frame_start = 1'b0;
    half_cfg           = 1'b0;
    row_len_cfg        = ROW_LEN_W'(320);
    col_pos            = 0;
    odd_row            = 1'b0;
    error_count        = 0;
    items_sent         = 0;
    cycles             = 0;
    hold_request       = 0;
    src_idling         = 1'b0;
    sink_idling        = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_full_mode_extremes();
    src_idling = 1'b1;
    test_half_mode_average();
    test_row_length_limits();
    test_output_backpressure();
    test_random_traffic();

    mp_bus.valid = 1'b0;
    while (pixel_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
